// ===== rtl/core/sha256_stream_hasher_defines.svh =====
// ----------------------------------------------------------------------------
// sha256 stream hasher assertion macros
// concurrent check helpers shared by the hasher rtl, sampled on clk,
// muted while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// same-cycle implication
`define SHA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256 package
// word types, initial hash, round constants and the sha-256 mixing functions
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

  typedef logic [31:0] word_t;
  // index 0 is word a / H0
  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic load;  // copy the chaining value into the working words
    logic step;  // run one round
  } core_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PAD    = 4'b0010,
    S_ROUND  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  localparam int RoundCount = 64;

  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PadMark     = 8'h80;
  // length field starts at bit 448 of the block
  localparam logic [5:0] LenStartPos = 6'd56;
  localparam logic [5:0] PosLast     = 6'd63;

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h00000000;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256 stream hasher
// byte-stream sha-256 with padding and an eight-word digest stream
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                  | marker
//  --------+-----+------------------------------------------+-------------------
//  in_     | in  | tdata[7:0] message byte                  | tlast = last byte
//  out_    | out | tdata[31:0] digest word, [34:32] index   | tlast = eighth word
//
//  message bytes are taken while the sequencer is idle; the 64th byte of a
//  block starts a compression (64 rounds on the shared round core plus the
//  chaining add), and no byte is taken until the chaining add is done
//  after the last byte the padder inserts one pad byte a cycle (up to 72)
//  with one or two more compressions, then hands the digest to the output
//  buffer, held off until the previous digest has fully drained
//  digest words leave from their own buffer, so the next message can be
//  taken while they drain; in_tready is low during padding and rounds
//  reset (rst_n, synchronous) restores the initial hash and an empty block
//
`default_nettype none

`include "sha256_stream_hasher_defines.svh"

module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        out_tlast   // last_word
);
  import sha256_pkg::*;

  // sequencer and message state
  state_t      state_r, state_nxt;
  hash_t       hash_r, hash_nxt;
  logic [63:0] bit_count_r, bit_count_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic        padding_r, padding_nxt;   // message done, padding in flight
  logic        mark_r, mark_nxt;         // 0x80 byte still to insert
  logic        len_ok_r, len_ok_nxt;     // current block carries the length
  logic        pad_last_r, pad_last_nxt; // this compression ends the message

  // block packing / message schedule window
  logic [23:0] acc_r, acc_nxt;
  word_t       win_r [16];
  word_t       win_nxt [16];

  // digest output buffer
  word_t       obuf_r [8];
  word_t       obuf_nxt [8];
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_cnt_r, out_cnt_nxt;

  // byte write port into the block
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [7:0]  pad_byte;
  logic [7:0]  len_byte;
  logic [5:0]  len_sel;
  word_t       sched_w;

  core_ctl_t   core_ctl;
  hash_t       core_work;

  sha256_round_core u_core (
    .clk     (clk),
    .ctl     (core_ctl),
    .hash_in (hash_r),
    .w_in    (win_r[0]),
    .k_in    (round_k(rnd_r[5:0])),
    .work_o  (core_work)
  );

  // length bytes go out msb first at positions 56..63
  assign len_sel  = {~pos_r[2:0], 3'b000};
  assign len_byte = bit_count_r[len_sel +: 8];
  assign pad_byte = mark_r ? PadMark :
                    (len_ok_r && (pos_r >= LenStartPos)) ? len_byte : 8'h00;

  // next schedule word w[t+16] from the sliding window
  assign sched_w = win_r[0] + small_sigma0(win_r[1]) + win_r[9] + small_sigma1(win_r[14]);

  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    bit_count_nxt = bit_count_r;
    pos_nxt       = pos_r;
    rnd_nxt       = rnd_r;
    padding_nxt   = padding_r;
    mark_nxt      = mark_r;
    len_ok_nxt    = len_ok_r;
    pad_last_nxt  = pad_last_r;
    acc_nxt       = acc_r;
    win_nxt       = win_r;
    obuf_nxt      = obuf_r;
    out_valid_nxt = out_valid_r;
    out_cnt_nxt   = out_cnt_r;
    wr_en         = 1'b0;
    wr_byte       = in_tdata;
    core_ctl      = '0;

    // digest drain, one word per transaction
    if (out_valid_r && out_tready) begin
      for (int i = 0; i < 7; i++) begin
        obuf_nxt[i] = obuf_r[i + 1];
      end
      out_cnt_nxt = out_cnt_r + 3'd1;
      if (out_cnt_r == 3'd7) begin
        out_valid_nxt = 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          wr_en         = 1'b1;
          wr_byte       = in_tdata;
          bit_count_nxt = bit_count_r + 64'd8;
          if (in_tlast) begin
            padding_nxt = 1'b1;
            mark_nxt    = 1'b1;
          end
          if (pos_r == PosLast) begin
            state_nxt = S_ROUND;
          end else if (in_tlast) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        wr_en    = 1'b1;
        wr_byte  = pad_byte;
        mark_nxt = 1'b0;
        // marker early enough: length fits in this block
        if (mark_r && (pos_r < LenStartPos)) begin
          len_ok_nxt = 1'b1;
        end
        if (pos_r == PosLast) begin
          if (len_ok_r) begin
            pad_last_nxt = 1'b1;
          end else begin
            len_ok_nxt = 1'b1;
          end
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        if (rnd_r == 7'(RoundCount)) begin
          for (int i = 0; i < 8; i++) begin
            hash_nxt[i] = hash_r[i] + core_work[i];
          end
          rnd_nxt = '0;
          if (pad_last_r) begin
            state_nxt = S_FINISH;
          end else if (padding_r) begin
            state_nxt = S_PAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          core_ctl.step = 1'b1;
          for (int i = 0; i < 15; i++) begin
            win_nxt[i] = win_r[i + 1];
          end
          win_nxt[15] = sched_w;
          rnd_nxt     = rnd_r + 7'd1;
        end
      end
      S_FINISH: begin
        // wait for the previous digest to drain
        if (!out_valid_r) begin
          for (int i = 0; i < 8; i++) begin
            obuf_nxt[i] = hash_r[i];
          end
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = '0;
          hash_nxt      = InitHash;
          bit_count_nxt = '0;
          padding_nxt   = 1'b0;
          len_ok_nxt    = 1'b0;
          pad_last_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // byte packing: big-endian words shift into the window
    if (wr_en) begin
      pos_nxt = pos_r + 6'd1;
      acc_nxt = {acc_r[15:0], wr_byte};
      if (pos_r[1:0] == 2'b11) begin
        for (int i = 0; i < 15; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[15] = {acc_r, wr_byte};
      end
      if (pos_r == PosLast) begin
        core_ctl.load = 1'b1;
        rnd_nxt       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hash_r      <= InitHash;
      bit_count_r <= '0;
      pos_r       <= '0;
      rnd_r       <= '0;
      padding_r   <= 1'b0;
      mark_r      <= 1'b0;
      len_ok_r    <= 1'b0;
      pad_last_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      bit_count_r <= bit_count_nxt;
      pos_r       <= pos_nxt;
      rnd_r       <= rnd_nxt;
      padding_r   <= padding_nxt;
      mark_r      <= mark_nxt;
      len_ok_r    <= len_ok_nxt;
      pad_last_r  <= pad_last_nxt;
      out_valid_r <= out_valid_nxt;
      out_cnt_r   <= out_cnt_nxt;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    win_r  <= win_nxt;
    obuf_r <= obuf_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_cnt_r, obuf_r[0]};
  assign out_tlast  = (out_cnt_r == 3'd7);

  // checks

  // a last-byte transaction always starts padding
  `SHA_ASSERT_NEXT(a_last_starts_pad, in_tvalid && in_tready && in_tlast, padding_r, "last byte did not start padding")
  // padding always ends on a block boundary and hands off word zero
  `SHA_ASSERT_NEXT(a_finish_handoff, (state_r == S_FINISH) && !out_valid_r, out_tvalid && (out_cnt_r == 3'd0) && (pos_r == 6'd0) && (state_r == S_IDLE), "digest handoff out of step")
  // the sequencer leaves the round state after the chaining add
  `SHA_ASSERT_NEXT(a_round_exit, (state_r == S_ROUND) && (rnd_r == 7'(RoundCount)), (state_r != S_ROUND) && (rnd_r == 7'd0), "round counter overran")
  // the round counter never passes the chaining-add slot
  `SHA_ASSERT_SAME(a_round_bound, state_r == S_ROUND, rnd_r <= 7'(RoundCount), "round counter out of range")

endmodule

`default_nettype wire

// ===== rtl/core/sha256_round_core.sv =====
// ----------------------------------------------------------------------------
// sha256 round core
// working words a..h and the shared one-round compression datapath
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_round_core (
  input  logic                  clk,
  input  sha256_pkg::core_ctl_t ctl,
  input  sha256_pkg::hash_t     hash_in,
  input  sha256_pkg::word_t     w_in,
  input  sha256_pkg::word_t     k_in,
  output sha256_pkg::hash_t     work_o
);
  import sha256_pkg::*;

  hash_t work_r;
  hash_t work_nxt;
  word_t t1;
  word_t t2;
  word_t chs;
  word_t mj;

  always_comb begin
    chs = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
    mj  = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
    t1  = work_r[7] + big_sigma1(work_r[4]) + chs + k_in + w_in;
    t2  = big_sigma0(work_r[0]) + mj;
    work_nxt = work_r;
    if (ctl.load) begin
      work_nxt = hash_in;
    end else if (ctl.step) begin
      work_nxt[7] = work_r[6];
      work_nxt[6] = work_r[5];
      work_nxt[5] = work_r[4];
      work_nxt[4] = work_r[3] + t1;
      work_nxt[3] = work_r[2];
      work_nxt[2] = work_r[1];
      work_nxt[1] = work_r[0];
      work_nxt[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  assign work_o = work_r;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// sha256 stream hasher testbench
// streams byte messages into the hasher with random source and sink gaps,
// predicts every digest with a local sha-256 model and checks each digest
// word, its index and its last flag in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 250;
  localparam int RandomItems = 370;
  localparam int HoldAt      = 120;   // bytes taken before the long sink stall
  localparam int HoldCycles  = 1500;

  // initial chaining value, index 0 is H0
  localparam logic [0:7][31:0] IvWords = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // round constants, index 0 first
  localparam logic [0:63][31:0] RoundK = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // one message byte waiting to be sent
  typedef struct {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  // one predicted digest transaction
  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        tail;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tlast = 1'b0;    // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;          // [31:0] digest_word, [34:32] word_index
  logic        out_tlast;          // last_word

  msg_byte_t    byte_queue [$];    // bytes still to be offered
  digest_beat_t digest_queue [$];  // digest words predicted but not yet seen

  // predictor state
  logic [31:0] chain_hash [8];
  logic [31:0] msg_block [16];
  logic [63:0] msg_bits;
  logic [5:0]  blk_pos;

  int errors = 0;
  int cycle_count = 0;
  int bytes_taken = 0;
  int total_items = 0;

  // source side pacing
  int   src_wait = 0;
  logic src_calm = 1'b0;
  msg_byte_t next_byte;

  // sink side pacing
  int   sink_wait = 0;
  int   sink_gap;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic sink_calm = 1'b1;

  digest_beat_t want;

  sha256_stream_hasher DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // 10 ns clock
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // local sha-256 model
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of msg_block into chain_hash
  task automatic compress_block();
    logic [31:0] sched [64];
    logic [31:0] wv [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) sched[i] = msg_block[i];
    for (int i = 16; i < 64; i++) begin
      s0 = rot_right(sched[i-15], 7) ^ rot_right(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = rot_right(sched[i-2], 17) ^ rot_right(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) wv[i] = chain_hash[i];
    for (int r = 0; r < 64; r++) begin
      // wv[0..7] are the working words a..h
      t1 = wv[7] + (rot_right(wv[4], 6) ^ rot_right(wv[4], 11) ^ rot_right(wv[4], 25))
         + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + RoundK[r] + sched[r];
      t2 = (rot_right(wv[0], 2) ^ rot_right(wv[0], 13) ^ rot_right(wv[0], 22))
         + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
      wv[7] = wv[6];
      wv[6] = wv[5];
      wv[5] = wv[4];
      wv[4] = wv[3] + t1;
      wv[3] = wv[2];
      wv[2] = wv[1];
      wv[1] = wv[0];
      wv[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_hash[i] = chain_hash[i] + wv[i];
  endtask

  // big-endian byte packing, compress on a full block
  task automatic absorb_byte(input logic [7:0] b);
    logic [4:0] shift;
    shift = 5'd24 - {blk_pos[1:0], 3'b000};
    if (blk_pos[1:0] == 2'd0) begin
      msg_block[blk_pos[5:2]] = {24'h0, b} << shift;
    end else begin
      msg_block[blk_pos[5:2]] = msg_block[blk_pos[5:2]] | ({24'h0, b} << shift);
    end
    blk_pos = blk_pos + 6'd1;
    if (blk_pos == 6'd0) compress_block();
  endtask

  task automatic clear_digest_state();
    for (int i = 0; i < 8; i++) chain_hash[i] = IvWords[i];
    msg_bits = 64'd0;
    blk_pos  = 6'd0;
  endtask

  // fold in one accepted byte; on the last byte pad and queue the digest
  task automatic hash_byte(input logic [7:0] data, input logic last);
    logic [63:0] bit_len;
    digest_beat_t beat;
    absorb_byte(data);
    msg_bits = msg_bits + 64'd8;
    if (last) begin
      bit_len = msg_bits;
      absorb_byte(8'h80);
      while (blk_pos != 6'd56) absorb_byte(8'h00);
      for (int i = 7; i >= 0; i--) absorb_byte(bit_len[8*i +: 8]);
      for (int i = 0; i < 8; i++) begin
        beat.word  = chain_hash[i];
        beat.index = 3'(i);
        beat.tail  = (i == 7);
        digest_queue = {digest_queue, beat};
      end
      clear_digest_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_byte(input logic [7:0] data, input logic last);
    msg_byte_t item;
    item.data = data;
    item.last = last;
    byte_queue = {byte_queue, item};
    total_items++;
  endtask

  task automatic add_random_message(input int len);
    for (int i = 0; i < len; i++) add_byte(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued bytes, holds each one until the handshake
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tlast  <= 1'b0;
      src_wait  <= 0;
    end else begin
      // switch between gap-free bursts and gappy stretches now and then
      if ($urandom_range(0, 31) == 0) src_calm <= ~src_calm;
      if (in_tvalid && !in_tready) begin
        // stalled, keep the transaction steady
      end else if (src_wait > 0) begin
        in_tvalid <= 1'b0;
        src_wait  <= src_wait - 1;
      end else if (byte_queue.size() > 0) begin
        next_byte = byte_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_byte.data;
        in_tlast  <= next_byte.last;
        // gap drawn here applies once this byte is taken
        src_wait  <= src_calm ? 0 : $urandom_range(0, 15);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sink: random ready gaps plus one long hold-off to back the block up
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_wait  <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else begin
      if ($urandom_range(0, 31) == 0) sink_calm <= ~sink_calm;
      if (!hold_done && bytes_taken >= HoldAt) begin
        hold_done  <= 1'b1;
        hold_left  <= HoldCycles;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        sink_gap = sink_calm ? 0 : $urandom_range(0, 15);
        sink_wait  <= sink_gap;
        out_tready <= (sink_gap == 0);
      end else if (sink_wait > 0) begin
        sink_wait  <= sink_wait - 1;
        out_tready <= (sink_wait == 1);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on accepted bytes, checks every digest transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        hash_byte(in_tdata, in_tlast);
        bytes_taken <= bytes_taken + 1;
      end
      if (out_tvalid && out_tready) begin
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest transaction: expected none, got %h (index %0d)",
                   $time, out_tdata[31:0], out_tdata[34:32]);
          errors++;
        end else begin
          want = digest_queue.pop_front();
          if (out_tdata[31:0] !== want.word) begin
            $display("%0t: digest_word %0d: expected %h, got %h",
                     $time, want.index, want.word, out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[34:32] !== want.index) begin
            $display("%0t: word_index: expected %0d, got %0d",
                     $time, want.index, out_tdata[34:32]);
            errors++;
          end
          if (out_tlast !== want.tail) begin
            $display("%0t: last_word at index %0d: expected %b, got %b",
                     $time, want.index, want.tail, out_tlast);
            errors++;
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("sha256_stream_hasher: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    clear_digest_state();

    // single-byte messages at both byte extremes
    add_byte(8'h00, 1'b1);
    add_byte(8'hff, 1'b1);
    // a short message walking through alternating bit patterns
    for (int i = 0; i < 22; i++) begin
      case (i % 4)
        0: add_byte(8'hff, i == 21);
        1: add_byte(8'h00, i == 21);
        2: add_byte(8'ha5, i == 21);
        default: add_byte(8'h5a, i == 21);
      endcase
    end

    // random messages: mostly short, some right at the padding boundaries
    while (total_items < RandomItems) begin
      if ($urandom_range(0, 9) < 7) begin
        add_random_message($urandom_range(1, 16));
      end else begin
        case ($urandom_range(0, 5))
          0: add_random_message(55);   // pad fits the same block
          1: add_random_message(56);   // length spills into a second block
          2: add_random_message(57);
          3: add_random_message(63);
          4: add_random_message(64);   // exactly one full block
          default: add_random_message(65);
        endcase
      end
    end

    // hold reset, then release it once
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // sample on the falling edge so all clocked updates have settled
    do @(negedge clk);
    while (byte_queue.size() != 0 || in_tvalid || digest_queue.size() != 0);

    // let the block settle, anything extra shows up as unexpected
    repeat (DrainCycles) @(negedge clk);

    if (errors == 0 && digest_queue.size() == 0) begin
      $display("sha256_stream_hasher: match");
    end else begin
      $display("sha256_stream_hasher: mismatch");
    end
    $finish;
  end

endmodule

// ===== sha256_stream_hasher.f =====
+incdir+rtl/core
rtl/core/sha256_pkg.sv
rtl/core/sha256_round_core.sv
rtl/core/sha256_stream_hasher.sv
tb/sv/tb.sv
